// ===== src/egs_pkg.sv =====
package egs_pkg;

    // Item kinds carried on the input tuser.
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_PAUSE  = 2'd3;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_SEQ_LENGTH     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EVENT_COUNT    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROTATION       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RISE_THRESHOLD = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FALL_THRESHOLD = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_GATE_TICKS     = 3'd5;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 7;
    localparam int ROT_W    = 6;
    localparam int TICK_W   = 16;
    localparam int STEP_OUT_W = 6;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // Result item, highest field first when packed into tdata (gate_out is bit 0).
    typedef struct packed {
        logic [M_DATA_W-10:0]  pad;
        logic                  event_fired;
        logic                  clock_edge;
        logic [STEP_OUT_W-1:0] step_now;
        logic                  gate_out;
    } result_t;

endpackage

// ===== src/euclidean_gate_sequencer.sv =====
// Channel   Dir  Handshake                 Payload
// s_        in   s_tvalid / s_tready       s_tdata: cv_sample; s_tuser: opcode
// m_        out  m_tvalid / m_tready       m_tdata: gate_out, step_now, clock_edge,
//                                           event_fired
// cfg_      in   cfg_wr_en                 cfg_addr: register index; cfg_wdata
//
// A tick, clear, pause toggle or sample without an unpaused rising edge passes through the
// evaluate and finish states; its result is registered once the output register is free.
// An unpaused rising edge also runs the shared restoring divider in three passes (step
// wrap, rotation reduction, pattern test), with mix, multiply and load states before the
// last pass. One item is in work at a time; s_tready is high only while idle.
// A waiting result is held in the output register while the next item is taken in.
// Reset (aresetn low, synchronous) restores register defaults, control and channel state.
module euclidean_gate_sequencer #(
    parameter int MAX_STEPS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // cfg port
    input  logic                           cfg_wr_en,
    input  logic [egs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [egs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [egs_pkg::S_DATA_W-1:0]   s_tdata,  // [15:0] cv_sample
    input  logic [egs_pkg::OP_W-1:0]       s_tuser,  // [1:0] opcode
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [egs_pkg::M_DATA_W-1:0]   m_tdata   // [0] gate_out, [6:1] step_now,
                                                     // [7] clock_edge, [8] event_fired
);
    import egs_pkg::*;

    localparam int SW      = (MAX_STEPS > 2) ? $clog2(MAX_STEPS) : 1;
    localparam int LEN_CAP = (MAX_STEPS > 127) ? 127 : MAX_STEPS;
    localparam int NUM_W   = 16;
    localparam int DIV_W   = 8;
    localparam int CNT_W   = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_MIX    = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_QLOAD  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    localparam logic [1:0] PH_STEP = 2'd0;
    localparam logic [1:0] PH_ROT  = 2'd1;
    localparam logic [1:0] PH_EVT  = 2'd2;

    // Configuration registers.
    logic [LEN_W-1:0]         seq_length_reg;
    logic [LEN_W-1:0]         event_count_reg;
    logic [ROT_W-1:0]         rotation_reg;
    logic signed [SAMPLE_W-1:0] rise_thr_reg;
    logic signed [SAMPLE_W-1:0] fall_thr_reg;
    logic [TICK_W-1:0]        gate_ticks_reg;

    // Channel state.
    logic [SW-1:0]     step_reg, step_next;
    logic              input_high_reg, input_high_next;
    logic              paused_reg, paused_next;
    logic [TICK_W-1:0] gate_age_reg, gate_age_next;
    logic              gate_level_reg, gate_level_next;

    // Sequencer control.
    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       edge_reg, edge_next;
    logic       fired_reg, fired_next;
    logic       m_valid_reg, m_valid_next;

    // Item and work registers.
    logic [OP_W-1:0]       op_reg, op_next;
    logic [SAMPLE_W-1:0]   sample_reg, sample_next;
    logic [LEN_W-1:0]      rotr_reg, rotr_next;
    logic [LEN_W-1:0]      m_reg, m_next;
    logic [2*LEN_W-1:0]    prod_reg, prod_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [DIV_W-1:0]      div_reg, div_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    result_t               out_reg, out_next;

    // Effective length and event count.
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] ev;
    always_comb begin
        if (seq_length_reg == '0) begin
            len = LEN_W'(1);
        end else if (32'(seq_length_reg) > LEN_CAP) begin
            len = LEN_W'(LEN_CAP);
        end else begin
            len = seq_length_reg;
        end
        if (event_count_reg == '0) begin
            ev = LEN_W'(1);
        end else if (event_count_reg > len) begin
            ev = len;
        end else begin
            ev = event_count_reg;
        end
    end

    // One restoring division step: shift in the next numerator bit, subtract if it fits.
    logic [DIV_W:0]   trial;
    logic             trial_fits;
    logic [DIV_W-1:0] rem_step;
    always_comb begin
        trial      = {rem_reg, num_reg[NUM_W-1]};
        trial_fits = trial >= {1'b0, div_reg};
        rem_step   = trial_fits ? DIV_W'(trial - {1'b0, div_reg}) : trial[DIV_W-1:0];
    end

    // Hysteresis detector on the held sample. The falling test comes first, so an input
    // that drops on this sample may rise again on the same sample.
    logic high_after_fall;
    logic rise_seen;
    always_comb begin
        high_after_fall = input_high_reg && ($signed(sample_reg) < fall_thr_reg);
        rise_seen       = (!input_high_reg || high_after_fall)
                       && ($signed(sample_reg) > rise_thr_reg);
    end

    // Rotated step position, reduced once against the length.
    logic [DIV_W-1:0] m_sum;
    always_comb begin
        m_sum = DIV_W'(step_reg) + {1'b0, rotr_reg};
        if (m_sum >= {1'b0, len}) begin
            m_sum = m_sum - {1'b0, len};
        end
    end

    // Pattern test on the final remainder: fire when L-E <= r < L+E.
    logic fire_hit;
    always_comb begin
        fire_hit = (rem_step >= {1'b0, len - ev})
                && (rem_step < ({1'b0, len} + {1'b0, ev}));
    end

    logic [SW+STEP_OUT_W-1:0] step_wide;
    assign step_wide = {{STEP_OUT_W{1'b0}}, step_reg};

    logic [TICK_W-1:0] age_inc;
    assign age_inc = (gate_age_reg == '1) ? gate_age_reg : gate_age_reg + 1'b1;

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        edge_next       = edge_reg;
        fired_next      = fired_reg;
        step_next       = step_reg;
        input_high_next = input_high_reg;
        paused_next     = paused_reg;
        gate_age_next   = gate_age_reg;
        gate_level_next = gate_level_reg;
        op_next         = op_reg;
        sample_next     = sample_reg;
        rotr_next       = rotr_reg;
        m_next          = m_reg;
        prod_next       = prod_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        cnt_next        = cnt_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next     = s_tuser;
                    sample_next = s_tdata;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                edge_next  = 1'b0;
                fired_next = 1'b0;
                state_next = ST_FINISH;
                case (op_reg)
                    OP_SAMPLE: begin
                        input_high_next = high_after_fall ? 1'b0 : input_high_reg;
                        if (rise_seen) begin
                            input_high_next = 1'b1;
                            gate_age_next   = '0;
                            if (!paused_reg) begin
                                // Wrap the advanced step against the length.
                                num_next   = NUM_W'(step_reg) + NUM_W'(1);
                                div_next   = DIV_W'(len);
                                rem_next   = '0;
                                cnt_next   = '0;
                                phase_next = PH_STEP;
                                state_next = ST_DIV;
                            end
                        end
                    end
                    OP_TICK: begin
                        gate_age_next = age_inc;
                        if (age_inc > gate_ticks_reg) begin
                            gate_level_next = 1'b0;
                        end
                    end
                    OP_CLEAR: begin
                        step_next = '0;
                    end
                    default: begin
                        paused_next = !paused_reg;
                    end
                endcase
            end
            ST_DIV: begin
                num_next = num_reg << 1;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    unique case (phase_reg)
                        PH_STEP: begin
                            step_next  = SW'(rem_step);
                            // Reduce the rotation against the length.
                            num_next   = NUM_W'(rotation_reg);
                            div_next   = DIV_W'(len);
                            rem_next   = '0;
                            cnt_next   = '0;
                            phase_next = PH_ROT;
                        end
                        PH_ROT: begin
                            rotr_next  = LEN_W'(rem_step);
                            state_next = ST_MIX;
                        end
                        PH_EVT: begin
                            edge_next  = 1'b1;
                            fired_next = fire_hit;
                            if (fire_hit) begin
                                gate_level_next = 1'b1;
                            end
                            state_next = ST_FINISH;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_MIX: begin
                m_next     = LEN_W'(m_sum);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = m_reg * ev;
                state_next = ST_QLOAD;
            end
            ST_QLOAD: begin
                // Divide 2*m*E + L by 2*L; only the remainder is needed.
                num_next   = {1'b0, prod_reg, 1'b0} + NUM_W'(len);
                div_next   = {len, 1'b0};
                rem_next   = '0;
                cnt_next   = '0;
                phase_next = PH_EVT;
                state_next = ST_DIV;
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_next.pad         = '0;
                    out_next.event_fired = fired_reg;
                    out_next.clock_edge  = edge_reg;
                    out_next.step_now    = step_wide[STEP_OUT_W-1:0];
                    out_next.gate_out    = gate_level_reg;
                    m_valid_next         = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and channel state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_STEP;
            edge_reg       <= 1'b0;
            fired_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
            step_reg       <= '0;
            input_high_reg <= 1'b0;
            paused_reg     <= 1'b0;
            gate_age_reg   <= '0;
            gate_level_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            edge_reg       <= edge_next;
            fired_reg      <= fired_next;
            m_valid_reg    <= m_valid_next;
            step_reg       <= step_next;
            input_high_reg <= input_high_next;
            paused_reg     <= paused_next;
            gate_age_reg   <= gate_age_next;
            gate_level_reg <= gate_level_next;
        end
    end

    // Work and payload registers.
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        sample_reg <= sample_next;
        rotr_reg   <= rotr_next;
        m_reg      <= m_next;
        prod_reg   <= prod_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        cnt_reg    <= cnt_next;
        out_reg    <= out_next;
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_length_reg  <= LEN_W'(16);
            event_count_reg <= LEN_W'(4);
            rotation_reg    <= '0;
            rise_thr_reg    <= SAMPLE_W'(6553);
            fall_thr_reg    <= SAMPLE_W'(1638);
            gate_ticks_reg  <= TICK_W'(10);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SEQ_LENGTH:     seq_length_reg  <= cfg_wdata[LEN_W-1:0];
                REG_EVENT_COUNT:    event_count_reg <= cfg_wdata[LEN_W-1:0];
                REG_ROTATION:       rotation_reg    <= cfg_wdata[ROT_W-1:0];
                REG_RISE_THRESHOLD: rise_thr_reg    <= $signed(cfg_wdata[SAMPLE_W-1:0]);
                REG_FALL_THRESHOLD: fall_thr_reg    <= $signed(cfg_wdata[SAMPLE_W-1:0]);
                REG_GATE_TICKS:     gate_ticks_reg  <= cfg_wdata[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

endmodule
